// ----- hw/rtl/cubic_bezier_point_eval_defines.svh -----
// Assertion macros for the curve evaluator RTL.
`ifndef CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH
`ifndef SYNTHESIS
`define CBEZ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CBEZ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBEZ_ASSERT_IMP(label, ante, cons, msg)
`define CBEZ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/cbez_pkg.sv -----
// Shared types and constants for the cubic Bezier point evaluator.
package cbez_pkg;

  localparam int CoordW     = 16;
  localparam int IdxW       = 10;
  localparam int NumRegs    = 8;
  localparam int RegIdxW    = 3;
  localparam int AddrW      = 5;
  localparam int ApbDataW   = 32;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 32;

  localparam int TgenStages = 5;
  localparam int LerpStages = 4;
  localparam int TailStages = 3 * LerpStages + 1;
  localparam int PipeStages = TgenStages + TailStages;

  // remainder division of the index term: dividend, quotient, reciprocal
  localparam int DivW       = 21;
  localparam int QuoW       = 11;
  localparam int RecipW     = 22;
  localparam int RecipShift = 21;

  typedef logic [CoordW-1:0] coord_t;
  typedef coord_t [NumRegs-1:0] cfg_regs_t;

  typedef enum logic [RegIdxW-1:0] {
    RegStartX,
    RegStartY,
    RegCtrlAX,
    RegCtrlAY,
    RegCtrlBX,
    RegCtrlBY,
    RegEndX,
    RegEndY
  } reg_idx_e;

  typedef struct packed {
    logic   last;
    coord_t y;
    coord_t x;
  } point_t;

endpackage

// ----- hw/rtl/cbez_regs.sv -----
// APB register file holding the four curve points.
module cbez_regs import cbez_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_regs_t           cfg_o
);

  cfg_regs_t cfg_q, cfg_d;
  reg_idx_e  reg_idx;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      cfg_d[reg_idx] = pwdata[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = ApbDataW'(cfg_q[reg_idx]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

// ----- hw/rtl/cbez_tgen.sv -----
// Pipelined clamp and rounded division of the sample index into the curve parameter t.
module cbez_tgen import cbez_pkg::*; #(
  parameter int SAMPLE_COUNT  = 100,
  parameter int FRACTION_BITS = 16,
  localparam int TW           = FRACTION_BITS + 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IdxW-1:0] idx_i,
  output logic [TW-1:0]   t_o,
  output logic            last_o
);

  // t = idx*A + floor((idx*B + L/2) / L), with 2^F = A*L + B
  localparam int Last   = SAMPLE_COUNT - 1;
  localparam int ACoefI = (1 << FRACTION_BITS) / Last;
  localparam int BCoefI = (1 << FRACTION_BITS) % Last;
  localparam int HalfI  = Last / 2;
  localparam int RecipI = (1 << RecipShift) / Last;
  localparam int ProdW  = TW + IdxW;
  localparam int MulW   = DivW + RecipW;

  localparam logic [IdxW-1:0]   LastV = IdxW'(Last);
  localparam logic [TW-1:0]     ACoef = TW'(ACoefI);
  localparam logic [IdxW-1:0]   BCoef = IdxW'(BCoefI);
  localparam logic [DivW-1:0]   HalfV = DivW'(HalfI);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipI);

  logic [IdxW-1:0] idx1_q;
  logic            last1_q, last2_q, last3_q, last4_q, last5_q;
  logic [DivW-1:0] d2_q, d3_q, d4_q;
  logic [TW-1:0]   p2_q, p3_q;
  logic [QuoW-1:0] qe3_q;
  logic [DivW-1:0] ql4_q;
  logic [TW-1:0]   pq4_q;
  logic [TW-1:0]   t5_q;

  logic [DivW-1:0] rem;

  assign rem = d4_q - ql4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx1_q  <= (idx_i > LastV) ? LastV : idx_i;
      last1_q <= (idx_i >= LastV);

      d2_q    <= DivW'(idx1_q) * DivW'(BCoef) + HalfV;
      p2_q    <= TW'(ProdW'(idx1_q) * ProdW'(ACoef));
      last2_q <= last1_q;

      qe3_q   <= QuoW'((MulW'(d2_q) * MulW'(Recip)) >> RecipShift);
      d3_q    <= d2_q;
      p3_q    <= p2_q;
      last3_q <= last2_q;

      ql4_q   <= DivW'(qe3_q) * DivW'(LastV);
      pq4_q   <= p3_q + TW'(qe3_q);
      d4_q    <= d3_q;
      last4_q <= last3_q;

      // estimate is low by at most one
      t5_q    <= pq4_q + TW'(rem >= DivW'(LastV));
      last5_q <= last4_q;
    end
  end

  assign t_o    = t5_q;
  assign last_o = last5_q;

endmodule

// ----- hw/rtl/cbez_lerp.sv -----
// Four-stage fixed-point linear interpolation step between two points.
module cbez_lerp import cbez_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  localparam int ValW         = CoordW + FRACTION_BITS,
  localparam int TW           = FRACTION_BITS + 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [ValW-1:0] a_i,
  input  logic [ValW-1:0] b_i,
  input  logic [TW-1:0]   t_i,
  output logic [ValW-1:0] y_o,
  output logic [TW-1:0]   t_o
);

  localparam int PhW = CoordW + TW;
  localparam int PlW = FRACTION_BITS + TW;

  logic            ge_d;
  logic [ValW-1:0] diff_d;

  logic [ValW-1:0] a1_q, a2_q, a3_q;
  logic            ge1_q, ge2_q, ge3_q;
  logic [ValW-1:0] diff1_q;
  logic [TW-1:0]   t1_q, t2_q, t3_q, t4_q;
  logic [PhW-1:0]  ph2_q;
  logic [PlW-1:0]  pl2_q;
  logic [ValW-1:0] step3_q;
  logic [ValW-1:0] y4_q;

  assign ge_d   = (b_i >= a_i);
  assign diff_d = ge_d ? (b_i - a_i) : (a_i - b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a_i;
      ge1_q   <= ge_d;
      diff1_q <= diff_d;
      t1_q    <= t_i;

      // split product: whole part and fraction part of the distance
      ph2_q   <= PhW'(diff1_q[ValW-1:FRACTION_BITS]) * PhW'(t1_q);
      pl2_q   <= PlW'(diff1_q[FRACTION_BITS-1:0]) * PlW'(t1_q);
      a2_q    <= a1_q;
      ge2_q   <= ge1_q;
      t2_q    <= t1_q;

      step3_q <= ValW'(ph2_q) + ValW'(pl2_q >> FRACTION_BITS);
      a3_q    <= a2_q;
      ge3_q   <= ge2_q;
      t3_q    <= t2_q;

      y4_q    <= ge3_q ? (a3_q + step3_q) : (a3_q - step3_q);
      t4_q    <= t3_q;
    end
  end

  assign y_o = y4_q;
  assign t_o = t4_q;

endmodule

// ----- hw/rtl/cbez_skid.sv -----
// Output register with a one-entry skid stage.
`include "cubic_bezier_point_eval_defines.svh"

module cbez_skid import cbez_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  point_t in_data_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  output point_t out_data_o,
  input  logic   out_ready_i
);

  logic   out_valid_q, out_valid_d;
  logic   skid_valid_q, skid_valid_d;
  point_t out_data_q, out_data_d;
  point_t skid_data_q, skid_data_d;
  logic   out_adv;

  assign out_adv = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_adv) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_data_d  = in_data_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CBEZ_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `CBEZ_ASSERT_NXT(a_stall_fills_skid, in_valid_i && !skid_valid_q && out_valid_q && !out_ready_i, skid_valid_q && out_valid_q, "stalled transfer not kept in skid")
  `CBEZ_ASSERT_NXT(a_skid_drains, skid_valid_q && out_ready_i, out_valid_q && !skid_valid_q, "skid not moved to output")

endmodule

// ----- hw/rtl/cubic_bezier_point_eval.sv -----
// Top level of the pipelined 2D cubic Bezier point evaluator.
//
// Usage: write P0..P3 over APB (eight 16-bit signed registers at byte
// addresses 0x00..0x1C: start x/y, control A x/y, control B x/y, end x/y)
// while the stream is idle. Each transfer on the slave stream carries a
// sample index in tdata[9:0]; indices at or above SAMPLE_COUNT clamp to
// the last sample. Each index yields one transfer on the master stream:
// x in tdata[15:0], y in tdata[31:16], tlast set for the last sample.
// Throughput is one point per cycle while the receiver keeps tready high.
// The path from the input transfer to the result on the master side has
// 5 stages that form t, three de Casteljau levels of 4 stages each, one
// stage that rounds, and the output register. Reset clears the registers
// to zero and empties the pipeline. When the receiver stalls, one result
// goes to a skid stage, then the whole pipeline holds and tready drops on the slave side.
module cubic_bezier_point_eval import cbez_pkg::*; #(
  parameter int SAMPLE_COUNT  = 100,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [9:0] sample_index
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [15:0] point_x, [31:16] point_y
  output logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int ValW = CoordW + FRACTION_BITS;
  localparam int TW   = FRACTION_BITS + 1;
  localparam logic [ValW-1:0] Half = ValW'(1) << (FRACTION_BITS - 1);

  localparam reg_idx_e PtReg [2][4] = '{
    '{RegStartX, RegCtrlAX, RegCtrlBX, RegEndX},
    '{RegStartY, RegCtrlAY, RegCtrlBY, RegEndY}
  };

  cfg_regs_t cfg;
  logic      pipe_en;

  logic [TW-1:0] t1;
  logic [TW-1:0] t2 [2];
  logic [TW-1:0] t3 [2];
  logic          last_t;

  logic [ValW-1:0] lift [2][4];
  logic [ValW-1:0] lvl1 [2][3];
  logic [ValW-1:0] lvl2 [2][2];
  logic [ValW-1:0] lvl3 [2];

  logic [PipeStages-1:0] vld_q;
  logic [TailStages-1:0] last_q;
  coord_t                rnd_d [2];
  coord_t                rnd_q [2];
  logic [ValW-1:0]       rsum [2];

  point_t out_point;
  point_t pipe_point;

  cbez_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbez_tgen #(
    .SAMPLE_COUNT  (SAMPLE_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_tgen (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .idx_i  (s_axis_tdata[IdxW-1:0]),
    .t_o    (t1),
    .last_o (last_t)
  );

  for (genvar c = 0; c < 2; c++) begin : g_axis
    for (genvar k = 0; k < 4; k++) begin : g_lift
      // offset to unsigned and scale by 2^F
      assign lift[c][k] = {~cfg[PtReg[c][k]][CoordW-1], cfg[PtReg[c][k]][CoordW-2:0],
                           {FRACTION_BITS{1'b0}}};
    end

    for (genvar j = 0; j < 3; j++) begin : g_lvl1
      if (j == 0) begin : g_tap
        cbez_lerp #(.FRACTION_BITS (FRACTION_BITS)) u_lerp (
          .clk_i (clk_i),
          .en_i  (pipe_en),
          .a_i   (lift[c][j]),
          .b_i   (lift[c][j+1]),
          .t_i   (t1),
          .y_o   (lvl1[c][j]),
          .t_o   (t2[c])
        );
      end else begin : g_plain
        cbez_lerp #(.FRACTION_BITS (FRACTION_BITS)) u_lerp (
          .clk_i (clk_i),
          .en_i  (pipe_en),
          .a_i   (lift[c][j]),
          .b_i   (lift[c][j+1]),
          .t_i   (t1),
          .y_o   (lvl1[c][j]),
          .t_o   ()
        );
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_lvl2
      if (j == 0) begin : g_tap
        cbez_lerp #(.FRACTION_BITS (FRACTION_BITS)) u_lerp (
          .clk_i (clk_i),
          .en_i  (pipe_en),
          .a_i   (lvl1[c][j]),
          .b_i   (lvl1[c][j+1]),
          .t_i   (t2[c]),
          .y_o   (lvl2[c][j]),
          .t_o   (t3[c])
        );
      end else begin : g_plain
        cbez_lerp #(.FRACTION_BITS (FRACTION_BITS)) u_lerp (
          .clk_i (clk_i),
          .en_i  (pipe_en),
          .a_i   (lvl1[c][j]),
          .b_i   (lvl1[c][j+1]),
          .t_i   (t2[c]),
          .y_o   (lvl2[c][j]),
          .t_o   ()
        );
      end
    end

    cbez_lerp #(.FRACTION_BITS (FRACTION_BITS)) u_lvl3 (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .a_i   (lvl2[c][0]),
      .b_i   (lvl2[c][1]),
      .t_i   (t3[c]),
      .y_o   (lvl3[c]),
      .t_o   ()
    );

    // round half up, then back to two's complement
    assign rsum[c]  = lvl3[c] + Half;
    assign rnd_d[c] = {~rsum[c][ValW-1], rsum[c][ValW-2:FRACTION_BITS]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PipeStages-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      last_q   <= {last_q[TailStages-2:0], last_t};
      rnd_q[0] <= rnd_d[0];
      rnd_q[1] <= rnd_d[1];
    end
  end

  assign pipe_point = '{last: last_q[TailStages-1], y: rnd_q[1], x: rnd_q[0]};

  cbez_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_q[PipeStages-1]),
    .in_data_i   (pipe_point),
    .in_ready_o  (pipe_en),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_point),
    .out_ready_i (m_axis_tready)
  );

  assign s_axis_tready = pipe_en;
  assign m_axis_tdata  = {out_point.y, out_point.x};
  assign m_axis_tlast  = out_point.last;

endmodule
